// File: rtl/merkle_range_proof_planner_assert.svh
// ----------------------------------------------------------------------------
// Merkle range proof planner assertion macros
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MERKLE_RANGE_PROOF_PLANNER_ASSERT_SVH
`define MERKLE_RANGE_PROOF_PLANNER_ASSERT_SVH

// same-cycle implication
`define MRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg
// Constants, types and helpers shared by the range proof planner modules.
// ----------------------------------------------------------------------------
package mrp_pkg;

	localparam int LEN_W       = 32;
	localparam int BLOCK_BYTES = 1024;
	localparam int HASH_BYTES  = 32;
	localparam int STACK_DEPTH = 24;

	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int HASH_SHIFT  = $clog2(HASH_BYTES);
	localparam int BLK_W       = LEN_W - BLOCK_SHIFT + 1;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
	localparam int HB_W        = 10;
	localparam int OFF_W       = 28;
	localparam int CNT_W       = 6;
	localparam int PAY_W       = 12;

	typedef logic [BLK_W-1:0] blk_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic push;
		logic pop;
		logic emit;
		logic send_held;
		logic send_final;
	} mrp_cmd_t;

	typedef struct packed {
		logic bad;
		logic outside;
		logic enclosed;
		logic stack_empty;
		logic held_valid;
		logic out_free;
	} mrp_sts_t;

	// isolate the highest set bit
	function automatic blk_t msb_onehot(input blk_t v);
		blk_t r;
		r = '0;
		for (int i = 0; i < BLK_W; i++) begin
			r[i] = v[i] & ~(|(v >> (i + 1)));
		end
		return r;
	endfunction

endpackage

// File: rtl/merkle_range_proof_planner.sv
// ----------------------------------------------------------------------------
// merkle_range_proof_planner
// Plans a Merkle range proof: head/tail extents and the subtree hash offsets.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall) takes total_length, range_start and
// range_end; a word is taken when valid is high and stall is low. Response
// channel (rsp_valid/rsp_stall) gives one word per needed subtree hash, left
// to right, the last word carrying sibling_count and payload_bytes. A range
// covering every block gives one word with sibling_valid low; a badly ordered
// request gives one word with bad_request and last_item set.
// One request is in flight at a time; req_stall is high from acceptance until
// the last word is loaded into the output register, so the next request can
// be taken while that word still waits.
// Flow: one setup step, then a visit to each tree node of the depth-first
// walk (about four per tree level, some 90 at full length), then the last
// word. The subtree stack and the node register hold the walk state.
// A stalled receiver holds the walk at the next subtree hash found.
// Reset clears the sequencer and the output valid; no sweep is needed.
// ----------------------------------------------------------------------------
module merkle_range_proof_planner import mrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [LEN_W-1:0]   total_length,
	input  logic [LEN_W-1:0]   range_start,
	input  logic [LEN_W-1:0]   range_end,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [LEN_W-1:0]   head_start,
	output logic [HB_W-1:0]    head_bytes,
	output logic [LEN_W-1:0]   tail_start,
	output logic [HB_W-1:0]    tail_bytes,
	output logic [OFF_W-1:0]   sibling_offset,
	output logic               sibling_valid,
	output logic [CNT_W-1:0]   sibling_count,
	output logic [PAY_W-1:0]   payload_bytes,
	output logic               bad_request,
	output logic               last_item
);

	mrp_cmd_t cmd;
	mrp_sts_t sts;

	mrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mrp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.total_length   (total_length),
		.range_start    (range_start),
		.range_end      (range_end),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.head_start     (head_start),
		.head_bytes     (head_bytes),
		.tail_start     (tail_start),
		.tail_bytes     (tail_bytes),
		.sibling_offset (sibling_offset),
		.sibling_valid  (sibling_valid),
		.sibling_count  (sibling_count),
		.payload_bytes  (payload_bytes),
		.bad_request    (bad_request),
		.last_item      (last_item)
	);

endmodule

// File: rtl/mrp_ctrl.sv
// ----------------------------------------------------------------------------
// mrp_ctrl
// Sequencer for the tree walk: accept, set up, walk one node a cycle unless the output stalls, finish.
// ----------------------------------------------------------------------------
module mrp_ctrl import mrp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  mrp_sts_t sts,
	output mrp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				if (sts.bad) begin
					state_d = ST_FINAL;
				end else if (sts.outside) begin
					if (!sts.held_valid || sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.send_held = sts.held_valid;
						if (sts.stack_empty) begin
							state_d = ST_FINAL;
						end else begin
							cmd.pop = 1'b1;
						end
					end
				end else if (sts.enclosed) begin
					if (sts.stack_empty) begin
						state_d = ST_FINAL;
					end else begin
						cmd.pop = 1'b1;
					end
				end else begin
					cmd.push = 1'b1;
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					cmd.send_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/mrp_dp.sv
// ----------------------------------------------------------------------------
// mrp_dp
// Request registers, node registers, subtree stack and output word register.
// ----------------------------------------------------------------------------
module mrp_dp import mrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mrp_cmd_t           cmd,
	output mrp_sts_t           sts,
	input  logic [LEN_W-1:0]   total_length,
	input  logic [LEN_W-1:0]   range_start,
	input  logic [LEN_W-1:0]   range_end,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [LEN_W-1:0]   head_start,
	output logic [HB_W-1:0]    head_bytes,
	output logic [LEN_W-1:0]   tail_start,
	output logic [HB_W-1:0]    tail_bytes,
	output logic [OFF_W-1:0]   sibling_offset,
	output logic               sibling_valid,
	output logic [CNT_W-1:0]   sibling_count,
	output logic [PAY_W-1:0]   payload_bytes,
	output logic               bad_request,
	output logic               last_item
);

	logic [LEN_W-1:0] len_q, rs_q, re_q;
	blk_t             bfrom_q, bto_q;
	logic [HB_W-1:0]  tb_q;
	logic             bad_q;
	blk_t             idx_q, nf_q, nt_q, m_q;
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OFF_W-1:0] held_q;
	logic             held_valid_q;
	logic             rsp_valid_q;

	blk_t stk_idx [STACK_DEPTH];
	blk_t stk_nf  [STACK_DEPTH];
	blk_t stk_nt  [STACK_DEPTH];
	blk_t stk_m   [STACK_DEPTH];

	// setup terms
	blk_t             blocks, m0, bto, bfrom;
	logic [HB_W-1:0]  tb_raw, tb;
	logic [LEN_W:0]   rem;
	logic             bad;

	// walk terms
	blk_t                       oh, ohm1, push_idx, mid;
	logic [BLK_W:0]             off_sum;
	logic [BLK_W+HASH_SHIFT:0]  off_full;
	logic [OFF_W-1:0]           emit_off;
	logic [PTR_W-1:0]           ptr_dec;
	logic [STK_AW-1:0]          wr_addr, rd_addr;

	// output terms
	logic [LEN_W-1:0] hstart;
	logic [HB_W-1:0]  hbytes;
	logic [PAY_W-1:0] payload;

	always_comb begin
		blocks = BLK_W'(len_q >> BLOCK_SHIFT) + BLK_W'(|len_q[BLOCK_SHIFT-1:0]);
		m0     = BLK_W'((len_q - 1'b1) >> BLOCK_SHIFT);
		bto    = BLK_W'(re_q >> BLOCK_SHIFT) + BLK_W'(|re_q[BLOCK_SHIFT-1:0]);
		bfrom  = BLK_W'(rs_q >> BLOCK_SHIFT);
		tb_raw = HB_W'(0) - re_q[HB_W-1:0];
		rem    = {1'b0, len_q} - {1'b0, re_q};
		tb     = (rem < (LEN_W + 1)'(tb_raw)) ? rem[HB_W-1:0] : tb_raw;
		bad    = (rs_q == '0) || (rs_q >= re_q) || (re_q > len_q);
	end

	always_comb begin
		oh       = msb_onehot(m_q);
		ohm1     = oh - 1'b1;
		push_idx = idx_q + (oh | ohm1);
		mid      = nf_q + oh;
		off_sum  = {1'b0, idx_q} + {m_q, 1'b0};
		off_full = {off_sum, {HASH_SHIFT{1'b0}}};
		emit_off = off_full[OFF_W-1:0];
		ptr_dec  = ptr_q - 1'b1;
		wr_addr  = ptr_q[STK_AW-1:0];
		rd_addr  = ptr_dec[STK_AW-1:0];
	end

	always_comb begin
		hstart  = {rs_q[LEN_W-1:BLOCK_SHIFT], {BLOCK_SHIFT{1'b0}}};
		hbytes  = rs_q[HB_W-1:0];
		payload = PAY_W'(hbytes) + PAY_W'(tb_q) + PAY_W'({cnt_q, {HASH_SHIFT{1'b0}}});
	end

	always_comb begin
		sts.bad         = bad_q;
		sts.outside     = (nt_q <= bfrom_q) || (nf_q >= bto_q);
		sts.enclosed    = (nf_q >= bfrom_q) && (nt_q <= bto_q);
		sts.stack_empty = (ptr_q == '0);
		sts.held_valid  = held_valid_q;
		sts.out_free    = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q <= total_length;
			rs_q  <= range_start;
			re_q  <= range_end;
		end
		if (cmd.setup) begin
			bfrom_q <= bfrom;
			bto_q   <= bto;
			tb_q    <= tb;
		end
		if (cmd.emit) begin
			held_q <= emit_off;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_idx[wr_addr] <= push_idx;
			stk_nf[wr_addr]  <= mid;
			stk_nt[wr_addr]  <= nt_q;
			stk_m[wr_addr]   <= m_q & ~oh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q        <= 1'b0;
			idx_q        <= '0;
			nf_q         <= '0;
			nt_q         <= '0;
			m_q          <= '0;
			ptr_q        <= '0;
			cnt_q        <= '0;
			held_valid_q <= 1'b0;
		end else if (cmd.setup) begin
			bad_q        <= bad;
			idx_q        <= '0;
			nf_q         <= '0;
			nt_q         <= blocks;
			m_q          <= m0;
			ptr_q        <= '0;
			cnt_q        <= '0;
			held_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				ptr_q <= ptr_q + 1'b1;
				nt_q  <= mid;
				m_q   <= ohm1;
			end else if (cmd.pop) begin
				ptr_q <= ptr_dec;
				idx_q <= stk_idx[rd_addr];
				nf_q  <= stk_nf[rd_addr];
				nt_q  <= stk_nt[rd_addr];
				m_q   <= stk_m[rd_addr];
			end
			if (cmd.emit) begin
				cnt_q        <= cnt_q + 1'b1;
				held_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.send_held || cmd.send_final) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.send_final && bad_q) begin
			head_start     <= '0;
			head_bytes     <= '0;
			tail_start     <= '0;
			tail_bytes     <= '0;
			sibling_offset <= '0;
			sibling_valid  <= 1'b0;
			sibling_count  <= '0;
			payload_bytes  <= '0;
			bad_request    <= 1'b1;
			last_item      <= 1'b1;
		end else if (cmd.send_held || cmd.send_final) begin
			head_start     <= hstart;
			head_bytes     <= hbytes;
			tail_start     <= re_q;
			tail_bytes     <= tb_q;
			sibling_offset <= held_valid_q ? held_q : '0;
			sibling_valid  <= held_valid_q;
			sibling_count  <= cmd.send_final ? cnt_q : '0;
			payload_bytes  <= cmd.send_final ? payload : '0;
			bad_request    <= 1'b0;
			last_item      <= cmd.send_final;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/mrp_checker.sv
// ----------------------------------------------------------------------------
// mrp_checker
// Port-level checks on the range proof planner, bound to the top level.
// ----------------------------------------------------------------------------
`include "merkle_range_proof_planner_assert.svh"

module mrp_checker import mrp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [LEN_W-1:0]   head_start,
	input logic               sibling_valid,
	input logic [CNT_W-1:0]   sibling_count,
	input logic [PAY_W-1:0]   payload_bytes,
	input logic               bad_request,
	input logic               last_item
);

	`MRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled word dropped")
	`MRP_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall, "second request taken")
	`MRP_ASSERT_NOW(a_bad_alone, rsp_valid && bad_request,
		last_item && !sibling_valid && (sibling_count == '0), "error word malformed")
	`MRP_ASSERT_NOW(a_mid_word, rsp_valid && !last_item,
		sibling_valid && (sibling_count == '0) && (payload_bytes == '0), "middle word malformed")
	`MRP_ASSERT_NOW(a_head_aligned, rsp_valid && !bad_request,
		head_start[BLOCK_SHIFT-1:0] == '0, "head start not block aligned")

endmodule

bind merkle_range_proof_planner mrp_checker u_mrp_checker (.*);

// File: tb/merkle_range_proof_planner_tb.sv
// ----------------------------------------------------------------------------
// merkle_range_proof_planner_tb
// Drives proof requests through the planner and checks every response word
// against a predictor that rounds the range out to blocks and walks the tree
// itself. Directed corner requests come first, then random requests, with
// random idling on both channels and one pause until all words are in.
// ----------------------------------------------------------------------------
module merkle_range_proof_planner_tb import mrp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT   = 36;
	localparam int RAND_ITEMS = 180;
	localparam int HANG_LIMIT = 5000;
	localparam int DRAIN_TAIL = 200;

	typedef struct packed {
		logic [LEN_W-1:0] head_start;
		logic [HB_W-1:0]  head_bytes;
		logic [LEN_W-1:0] tail_start;
		logic [HB_W-1:0]  tail_bytes;
		logic [OFF_W-1:0] sibling_offset;
		logic             sibling_valid;
		logic [CNT_W-1:0] sibling_count;
		logic [PAY_W-1:0] payload_bytes;
		logic             bad_request;
		logic             last_item;
	} proof_word_t;

	class proof_scoreboard;
		proof_word_t pending[$];
		int errors = 0;

		function void note_request(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] rs,
				input logic [LEN_W-1:0] re);
			logic [63:0] stk_idx [STACK_DEPTH];
			logic [63:0] stk_lo [STACK_DEPTH];
			logic [63:0] stk_hi [STACK_DEPTH];
			logic [63:0] offs[$];
			logic [63:0] blocks, bfrom, bto, idx, nf, nt, sp;
			logic [63:0] hstart, hbytes, tbytes, payload;
			int depth;
			int n;
			bit bad;
			proof_word_t w;
			bad = !(rs != 0 && rs < re && re <= len);
			if (!bad) begin
				blocks = (64'(len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
				bfrom = 64'(rs) / BLOCK_BYTES;
				bto = (64'(re) + BLOCK_BYTES - 1) / BLOCK_BYTES;
				idx = 0;
				nf = 0;
				nt = blocks;
				depth = 0;
				while (1'b1) begin
					if (nt <= bfrom || nf >= bto) begin
						if (offs.size() >= 44) begin
							bad = 1;
							break;
						end
						offs.push_back((idx + 2 * (nt - nf) - 2) * HASH_BYTES);
					end else if (!(nf >= bfrom && nt <= bto)) begin
						// largest power of two strictly below the span
						sp = 64'h4000_0000;
						if (nt - nf <= 1 || nt - nf > sp)
							sp = 0;
						else
							while (sp >= nt - nf) sp = sp >> 1;
						if (sp == 0 || depth >= STACK_DEPTH) begin
							bad = 1;
							break;
						end
						stk_idx[depth] = idx + 2 * sp - 1;
						stk_lo[depth] = nf + sp;
						stk_hi[depth] = nt;
						depth++;
						nt = nf + sp;
						continue;
					end
					if (depth == 0)
						break;
					depth--;
					idx = stk_idx[depth];
					nf = stk_lo[depth];
					nt = stk_hi[depth];
				end
			end
			if (bad) begin
				w = '0;
				w.bad_request = 1'b1;
				w.last_item = 1'b1;
				pending.push_back(w);
				return;
			end
			hstart = bfrom * BLOCK_BYTES;
			hbytes = 64'(rs) - hstart;
			tbytes = bto * BLOCK_BYTES - 64'(re);
			if (64'(re) + tbytes > 64'(len))
				tbytes = 64'(len) - 64'(re);
			payload = hbytes + tbytes + 64'(offs.size()) * HASH_BYTES;
			n = (offs.size() == 0) ? 1 : offs.size();
			for (int j = 0; j < n; j++) begin
				w = '0;
				w.head_start = LEN_W'(hstart);
				w.head_bytes = HB_W'(hbytes);
				w.tail_start = re;
				w.tail_bytes = HB_W'(tbytes);
				if (offs.size() != 0) begin
					w.sibling_offset = OFF_W'(offs[j]);
					w.sibling_valid = 1'b1;
				end
				if (j == n - 1) begin
					w.sibling_count = CNT_W'(offs.size());
					w.payload_bytes = PAY_W'(payload);
					w.last_item = 1'b1;
				end
				pending.push_back(w);
			end
		endfunction

		function void compare_field(input string name, input logic [63:0] exp_v,
				input logic [63:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v,
					act_v);
			end
		endfunction

		function void check_word(input proof_word_t got);
			proof_word_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected response word 0x%0h", $time, got);
				return;
			end
			want = pending.pop_front();
			compare_field("head_start", want.head_start, got.head_start);
			compare_field("head_bytes", want.head_bytes, got.head_bytes);
			compare_field("tail_start", want.tail_start, got.tail_start);
			compare_field("tail_bytes", want.tail_bytes, got.tail_bytes);
			compare_field("sibling_offset", want.sibling_offset, got.sibling_offset);
			compare_field("sibling_valid", want.sibling_valid, got.sibling_valid);
			compare_field("sibling_count", want.sibling_count, got.sibling_count);
			compare_field("payload_bytes", want.payload_bytes, got.payload_bytes);
			compare_field("bad_request", want.bad_request, got.bad_request);
			compare_field("last_item", want.last_item, got.last_item);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic [LEN_W-1:0] total_length = '0;
	logic [LEN_W-1:0] range_start = '0;
	logic [LEN_W-1:0] range_end = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	logic [LEN_W-1:0] head_start;
	logic [HB_W-1:0]  head_bytes;
	logic [LEN_W-1:0] tail_start;
	logic [HB_W-1:0]  tail_bytes;
	logic [OFF_W-1:0] sibling_offset;
	logic             sibling_valid;
	logic [CNT_W-1:0] sibling_count;
	logic [PAY_W-1:0] payload_bytes;
	logic             bad_request;
	logic             last_item;

	proof_scoreboard sb = new;
	bit calm = 1'b0;
	int quiet_cycles = 0;

	merkle_range_proof_planner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.total_length(total_length),
		.range_start(range_start),
		.range_end(range_end),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.head_start(head_start),
		.head_bytes(head_bytes),
		.tail_start(tail_start),
		.tail_bytes(tail_bytes),
		.sibling_offset(sibling_offset),
		.sibling_valid(sibling_valid),
		.sibling_count(sibling_count),
		.payload_bytes(payload_bytes),
		.bad_request(bad_request),
		.last_item(last_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_word('{head_start: head_start, head_bytes: head_bytes,
				tail_start: tail_start, tail_bytes: tail_bytes,
				sibling_offset: sibling_offset, sibling_valid: sibling_valid,
				sibling_count: sibling_count, payload_bytes: payload_bytes,
				bad_request: bad_request, last_item: last_item});
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: timeout, no word moved for %0d cycles", $time, quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// one request word; returns in the step of the accepting edge
	task automatic send_request(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] rs,
			input logic [LEN_W-1:0] re);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		total_length <= len;
		range_start <= rs;
		range_end <= re;
		do @(posedge clk); while (req_stall);
		sb.note_request(len, rs, re);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	task automatic send_random();
		logic [LEN_W-1:0] len, rs, re;
		int kind;
		kind = $urandom_range(99);
		if (kind < 15) begin
			// noise and broken orderings
			len = $urandom();
			rs = $urandom();
			re = $urandom();
			case (kind % 4)
				0: rs = 0;
				1: re = rs;
				2: if (len != '1) re = len + 1;
				default: ;
			endcase
		end else begin
			case ($urandom_range(2))
				0: len = $urandom_range(2, 20000);
				1: len = $urandom_range(2, 32'h0100_0000);
				default: len = $urandom_range(2, 32'hFFFF_FFFF);
			endcase
			rs = $urandom_range(1, len - 1);
			if ($urandom_range(1) == 0 && len - rs > 3000)
				re = rs + $urandom_range(1, 3000);
			else
				re = $urandom_range(rs + 1, len);
		end
		send_request(len, rs, re);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(32'd1, 32'd0, 32'd1);
		send_request(32'd0, 32'd0, 32'd0);
		send_request(32'd2, 32'd1, 32'd2);
		send_request(32'd100, 32'd5, 32'd5);
		send_request(32'd100, 32'd50, 32'd10);
		send_request(32'd100, 32'd10, 32'd101);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'd1, 32'd2);
		send_request(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_request(32'd2048, 32'd1023, 32'd1025);
		send_request(32'd2048, 32'd1024, 32'd2048);
		send_request(32'd3000, 32'd1, 32'd1024);
		send_request(32'h8000_0000, 32'h4000_0000, 32'h4000_0001);
		send_request(32'hFFFF_FFFF, 32'h0000_03FF, 32'h0000_0401);
		send_request(32'd5000, 32'd4097, 32'd4098);
		send_request(32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0);
		send_request(32'd1049600, 32'd1048576, 32'd1049600);
		send_request(32'hFFFF_FC00, 32'h7FFF_FFFF, 32'h8000_0001);
		send_request(32'h5555_5555, 32'h2AAA_AAAA, 32'h5555_5555);

		drain_responses();

		for (int i = 0; i < RAND_ITEMS; i++) begin
			calm = (i >= 70 && i < 110);
			send_random();
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (sb.pending.size() != 0)
			$display("%0t: %0d expected words never arrived", $time, sb.pending.size());
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
